// File: src/assert_macros.svh
// Assertion macros shared by the queue pair RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_CHECK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// cond must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rstn, cond) \
    `ASSERT_CHECK(label, clk, rstn, !(cond))
`else
`define ASSERT_CHECK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

// File: src/nvmeq_pkg.sv
// Shared types and constants for the NVMe I/O queue pair host block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package nvmeq_pkg;

    // port widths
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 264;

    // depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;

    // input item kinds (tuser)
    typedef enum logic [1:0] {
        CMD_SUBMIT   = 2'd0,
        CMD_COMPLETE = 2'd1,
        CMD_TICK     = 2'd2
    } cmd_t;

    // result item kinds (tuser)
    typedef enum logic [1:0] {
        KIND_ISSUED  = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_REJECT  = 2'd3
    } kind_t;

    // command opcodes
    localparam logic [1:0] OPC_WRITE = 2'd1;
    localparam logic [1:0] OPC_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NAMESPACE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_LOG2 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_IRQ     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 8'd3;

    // configuration reset values
    localparam logic [31:0] NAMESPACE_RESET   = 32'd1;
    localparam logic [3:0]  SECTOR_LOG2_RESET = 4'd9;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd5000;

    // sector size and count limits
    localparam logic [3:0] SECTOR_LOG2_MIN  = 4'd9;
    localparam logic [3:0] SECTOR_LOG2_MAX  = 4'd12;
    localparam logic [3:0] SECTOR_COUNT_MAX = 4'd8;

    // one classified item handed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  opcode;
        logic [15:0] command_id;
        logic [31:0] nsid;
        logic [63:0] prp1;
        logic [63:0] start_lba;
        logic [2:0]  blocks_minus_one;
        logic [1:0]  sector_log2_off;   // sector log2 minus 9
        logic [3:0]  command_slot;
        logic [3:0]  sq_db;
        logic [3:0]  cq_db;
        logic        failed;
    } rec_t;

endpackage

`default_nettype wire

// File: src/nvmeq_front.sv
// Front end: configuration registers, queue pointers and command state.
// Accepts input items, classifies them and pushes records; uses nvmeq_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nvmeq_front #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // configuration writes
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [nvmeq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [nvmeq_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [nvmeq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire  [1:0]                         s_axis_tuser,
    // records toward the back end
    output logic                               push_valid,
    input  wire                                push_ready,
    output nvmeq_pkg::rec_t                    push_rec
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    // configuration registers
    logic [31:0] namespace_reg;
    logic [3:0]  sector_log2_reg;
    logic        use_irq_reg;
    logic [15:0] timeout_reg;

    // queue state
    logic [PTR_W-1:0] sq_tail_reg, sq_tail_next;
    logic [PTR_W-1:0] cq_head_reg, cq_head_next;
    logic             phase_reg, phase_next;
    logic [15:0]      cmd_id_reg, cmd_id_next;
    logic             busy_reg, busy_next;
    logic [15:0]      elapsed_reg, elapsed_next;

    // input field views
    logic              s_fire;
    nvmeq_pkg::cmd_t   cmd;
    logic [63:0]       in_lba;
    logic [3:0]        in_count;
    logic [63:0]       in_buf;
    logic              in_write;
    logic [15:0]       in_word;

    logic [3:0]        count_sat;
    logic [3:0]        count_m1;
    logic [3:0]        log2_sat;
    logic [3:0]        log2_off;
    logic [PTR_W+3:0]  slot_ext;
    logic [PTR_W+3:0]  tail_ext;
    logic [PTR_W+3:0]  head_ext;
    logic [PTR_W-1:0]  tail_inc;
    logic [PTR_W-1:0]  head_inc;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = push_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign cmd      = nvmeq_pkg::cmd_t'(s_axis_tuser);
    assign in_lba   = s_axis_tdata[63:0];
    assign in_count = s_axis_tdata[67:64];
    assign in_buf   = s_axis_tdata[131:68];
    assign in_write = s_axis_tdata[132];
    assign in_word  = s_axis_tdata[148:133];

    // saturate sector count into 1..8 and sector log2 into 9..12
    always_comb begin
        if (in_count == 4'd0) begin
            count_sat = 4'd1;
        end else if (in_count > nvmeq_pkg::SECTOR_COUNT_MAX) begin
            count_sat = nvmeq_pkg::SECTOR_COUNT_MAX;
        end else begin
            count_sat = in_count;
        end
        if (sector_log2_reg < nvmeq_pkg::SECTOR_LOG2_MIN) begin
            log2_sat = nvmeq_pkg::SECTOR_LOG2_MIN;
        end else if (sector_log2_reg > nvmeq_pkg::SECTOR_LOG2_MAX) begin
            log2_sat = nvmeq_pkg::SECTOR_LOG2_MAX;
        end else begin
            log2_sat = sector_log2_reg;
        end
    end

    assign count_m1 = count_sat - 4'd1;
    assign log2_off = log2_sat - nvmeq_pkg::SECTOR_LOG2_MIN;

    // ring pointer increments with wrap at the queue depth
    assign tail_inc = (sq_tail_reg == PTR_LAST) ? '0 : sq_tail_reg + PTR_W'(1);
    assign head_inc = (cq_head_reg == PTR_LAST) ? '0 : cq_head_reg + PTR_W'(1);
    assign slot_ext = {4'b0, sq_tail_reg};
    assign tail_ext = {4'b0, tail_inc};
    assign head_ext = {4'b0, head_inc};

    // classify the item and update the queue state
    always_comb begin
        sq_tail_next = sq_tail_reg;
        cq_head_next = cq_head_reg;
        phase_next   = phase_reg;
        cmd_id_next  = cmd_id_reg;
        busy_next    = busy_reg;
        elapsed_next = elapsed_reg;
        push_valid   = 1'b0;
        push_rec     = '0;
        if (s_fire) begin
            unique case (cmd)
                nvmeq_pkg::CMD_SUBMIT: begin
                    push_valid = 1'b1;
                    if (busy_reg) begin
                        push_rec.kind = nvmeq_pkg::KIND_REJECT;
                    end else begin
                        push_rec.kind             = nvmeq_pkg::KIND_ISSUED;
                        push_rec.opcode           = in_write ? nvmeq_pkg::OPC_WRITE
                                                             : nvmeq_pkg::OPC_READ;
                        push_rec.command_id       = cmd_id_reg;
                        push_rec.nsid             = namespace_reg;
                        push_rec.prp1             = in_buf;
                        push_rec.start_lba        = in_lba;
                        push_rec.blocks_minus_one = count_m1[2:0];
                        push_rec.sector_log2_off  = log2_off[1:0];
                        push_rec.command_slot     = slot_ext[3:0];
                        push_rec.sq_db            = tail_ext[3:0];
                        sq_tail_next = tail_inc;
                        cmd_id_next  = cmd_id_reg + 16'd1;
                        busy_next    = 1'b1;
                        elapsed_next = 16'd0;
                    end
                end
                nvmeq_pkg::CMD_COMPLETE: begin
                    // only a word whose phase matches ends the wait
                    if (busy_reg && (in_word[0] == phase_reg)) begin
                        push_valid      = 1'b1;
                        push_rec.kind   = nvmeq_pkg::KIND_DONE;
                        push_rec.cq_db  = head_ext[3:0];
                        push_rec.failed = |in_word[15:1];
                        cq_head_next    = head_inc;
                        if (head_inc == '0) begin
                            phase_next = ~phase_reg;
                        end
                        busy_next = 1'b0;
                    end
                end
                nvmeq_pkg::CMD_TICK: begin
                    if (busy_reg && !use_irq_reg) begin
                        if (elapsed_reg >= timeout_reg) begin
                            push_valid      = 1'b1;
                            push_rec.kind   = nvmeq_pkg::KIND_TIMEOUT;
                            push_rec.failed = 1'b1;
                            busy_next       = 1'b0;
                        end else begin
                            elapsed_next = elapsed_reg + 16'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_tail_reg <= '0;
            cq_head_reg <= '0;
            phase_reg   <= 1'b1;
            cmd_id_reg  <= 16'd0;
            busy_reg    <= 1'b0;
            elapsed_reg <= 16'd0;
        end else begin
            sq_tail_reg <= sq_tail_next;
            cq_head_reg <= cq_head_next;
            phase_reg   <= phase_next;
            cmd_id_reg  <= cmd_id_next;
            busy_reg    <= busy_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            namespace_reg   <= nvmeq_pkg::NAMESPACE_RESET;
            sector_log2_reg <= nvmeq_pkg::SECTOR_LOG2_RESET;
            use_irq_reg     <= 1'b0;
            timeout_reg     <= nvmeq_pkg::TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                nvmeq_pkg::CFG_NAMESPACE:   namespace_reg   <= cfg_data;
                nvmeq_pkg::CFG_SECTOR_LOG2: sector_log2_reg <= cfg_data[3:0];
                nvmeq_pkg::CFG_USE_IRQ:     use_irq_reg     <= cfg_data[0];
                nvmeq_pkg::CFG_TIMEOUT:     timeout_reg     <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // an issued command always leaves the block busy
    `ASSERT_CHECK(a_issue_sets_busy, aclk, aresetn,
        (push_valid && push_rec.kind == nvmeq_pkg::KIND_ISSUED) |=> busy_reg)
    // a consumed completion or a timeout always frees the block
    `ASSERT_CHECK(a_done_clears_busy, aclk, aresetn,
        (push_valid && (push_rec.kind == nvmeq_pkg::KIND_DONE ||
                        push_rec.kind == nvmeq_pkg::KIND_TIMEOUT)) |=> !busy_reg)
    // a timeout leaves head and phase where they were
    `ASSERT_CHECK(a_timeout_keeps_head, aclk, aresetn,
        (push_valid && push_rec.kind == nvmeq_pkg::KIND_TIMEOUT)
            |=> ($stable(cq_head_reg) && $stable(phase_reg)))

endmodule

`default_nettype wire

// File: src/nvmeq_fifo.sv
// Short record queue between the front and the back end.
// Register storage, registered count; uses nvmeq_pkg::rec_t.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nvmeq_fifo #(
    parameter int DEPTH = 4
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              wr_valid,
    output logic             wr_ready,
    input  nvmeq_pkg::rec_t  wr_rec,
    output logic             rd_valid,
    input  wire              rd_ready,
    output nvmeq_pkg::rec_t  rd_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    nvmeq_pkg::rec_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_fire, rd_fire;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_rec   = mem_reg[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    // pointer and count bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_fire && !rd_fire) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rd_fire && !wr_fire) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    // the count tracks the distance between the pointers
    `ASSERT_CHECK(a_count_matches_ptrs, aclk, aresetn,
        (count_reg == '0 || count_reg == CNT_FULL) |-> (wr_ptr_reg == rd_ptr_reg))

endmodule

`default_nettype wire

// File: src/nvmeq_back.sv
// Back end: finishes each record (PRP2 page crossing) into the output register.
// Drives the result channel; uses nvmeq_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nvmeq_back #(
    parameter int PAGE_BYTES = 4096
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // records from the queue
    input  wire                                pop_valid,
    output logic                               pop_ready,
    input  nvmeq_pkg::rec_t                    pop_rec,
    // result items
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [nvmeq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                         m_axis_tuser
);

    localparam int PAGE_LOG2  = $clog2(PAGE_BYTES);
    localparam int PAGE_NUM_W = 64 - PAGE_LOG2;
    localparam int PAD_W      = nvmeq_pkg::OUT_TDATA_W - 258;

    logic            m_valid_reg;
    nvmeq_pkg::rec_t out_reg;
    logic [63:0]     prp2_reg, prp2_next;

    logic [3:0]            sec_count;
    logic [3:0]            sec_shift;
    logic [15:0]           xfer_len;
    logic [15:0]           xfer_len_m1;
    logic [63:0]           end_addr;
    logic                  crosses;
    logic [PAGE_NUM_W-1:0] next_page;

    // transfer length and last byte address
    assign sec_count   = {1'b0, pop_rec.blocks_minus_one} + 4'd1;
    assign sec_shift   = nvmeq_pkg::SECTOR_LOG2_MIN + {2'b0, pop_rec.sector_log2_off};
    assign xfer_len    = {12'b0, sec_count} << sec_shift;
    assign xfer_len_m1 = xfer_len - 16'd1;
    assign end_addr    = pop_rec.prp1 + {48'b0, xfer_len_m1};
    assign crosses     = (pop_rec.prp1[63:PAGE_LOG2] != end_addr[63:PAGE_LOG2]);
    assign next_page   = pop_rec.prp1[63:PAGE_LOG2] + PAGE_NUM_W'(1);

    // second pointer only for an issued command that runs into the next page
    always_comb begin
        prp2_next = 64'd0;
        if (pop_rec.kind == nvmeq_pkg::KIND_ISSUED && crosses) begin
            prp2_next = {next_page, {PAGE_LOG2{1'b0}}};
        end
    end

    assign pop_ready = !m_valid_reg || m_axis_tready;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop_ready) begin
            m_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ready && pop_valid) begin
            out_reg  <= pop_rec;
            prp2_reg <= prp2_next;
        end
    end

    // result packing
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {
        {PAD_W{1'b0}},
        out_reg.failed,
        out_reg.cq_db,
        out_reg.sq_db,
        out_reg.command_slot,
        out_reg.blocks_minus_one,
        out_reg.start_lba,
        prp2_reg,
        out_reg.prp1,
        out_reg.nsid,
        out_reg.command_id,
        out_reg.opcode
    };

    // only an issued command carries a second page pointer
    `ASSERT_NEVER(a_prp2_only_issued, aclk, aresetn,
        m_valid_reg && out_reg.kind != nvmeq_pkg::KIND_ISSUED && prp2_reg != 64'd0)

endmodule

`default_nettype wire

// File: src/nvme_io_queue_pair_host.sv
// Top level of the NVMe I/O queue pair host: front end, record queue, back end.
// Depends on nvmeq_pkg, nvmeq_front, nvmeq_fifo and nvmeq_back.
//
// Channel   Direction  Handshake                      Carries
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
// s_axis    in         s_axis_tvalid / s_axis_tready  request, completion word or tick
// m_axis    out        m_axis_tvalid / m_axis_tready  issued, done, timeout or reject
//
// One input item per cycle is accepted while the record queue has room; its result
// passes the record queue and then the output register before it shows on m_axis.
// A four-entry record queue parts the sides: s_axis_tready drops only when it is
// full because m_axis is stalled. Items that give no result still pass the front.
// aresetn is synchronous and active low; it clears pointers and counters, sets the
// phase to one and loads the configuration reset values. cfg_ready stays high.
`timescale 1ns / 1ps
`default_nettype none

module nvme_io_queue_pair_host #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PAGE_BYTES  = 4096
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // configuration
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [nvmeq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [nvmeq_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // lba[63:0], sectors[67:64], buffer_addr[131:68], is_write[132],
    // completion_word[148:133], zero[151:149]
    input  wire  [nvmeq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // cmd[1:0]
    input  wire  [1:0]                         s_axis_tuser,
    // result items
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // opcode[1:0], command_id[17:2], namespace_out[49:18], prp1[113:50],
    // prp2[177:114], start_lba[241:178], blocks_minus_one[244:242],
    // command_slot[248:245], sq_doorbell_value[252:249],
    // cq_doorbell_value[256:253], failed[257], zero[263:258]
    output logic [nvmeq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                         m_axis_tuser
);

    logic            push_valid, push_ready;
    nvmeq_pkg::rec_t push_rec;
    logic            pop_valid, pop_ready;
    nvmeq_pkg::rec_t pop_rec;

    nvmeq_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_rec      (push_rec)
    );

    nvmeq_fifo #(
        .DEPTH (nvmeq_pkg::FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_rec   (push_rec),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_rec   (pop_rec)
    );

    nvmeq_back #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_rec       (pop_rec),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
